### src/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock out of reset
`define CSEM_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define CSEM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### src/csem_pkg.sv
package csem_pkg;

  localparam int QUEUE_DEPTH_DEF    = 16;
  localparam int THREAD_ID_BITS_DEF = 8;
  localparam int CNT_BITS           = 16;
  localparam int APB_ADDR_BITS      = 3;
  localparam int APB_DATA_BITS      = 32;

  localparam logic signed [CNT_BITS-1:0] CNT_MIN  = 16'sh8000;
  localparam logic signed [CNT_BITS-1:0] CNT_MAX  = 16'sh7fff;
  localparam logic signed [CNT_BITS-1:0] CNT_ZERO = 16'sh0000;

  typedef enum logic [1:0] {
    CMD_WAIT   = 2'd0,
    CMD_SIGNAL = 2'd1,
    CMD_CLOSE  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_GRANTED  = 3'd0,
    KIND_BLOCKED  = 3'd1,
    KIND_WOKEN    = 3'd2,
    KIND_DONE     = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_WAKE
  } state_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### src/csem_queue.sv
module csem_queue
  import csem_pkg::*;
#(
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
  parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  q_ctl_t                    q_ctl,
  input  logic [THREAD_ID_BITS-1:0] push_id,
  output q_stat_t                   q_stat,
  output logic [THREAD_ID_BITS-1:0] rd_id
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
  localparam logic [FW-1:0] FULL_CNT = FW'(QUEUE_DEPTH);

  logic [THREAD_ID_BITS-1:0] mem [QUEUE_DEPTH];
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [FW-1:0] fill;

  always_ff @(posedge clk) begin
    if (q_ctl.push) begin
      mem[tail] <= push_id;
    end
    if (q_ctl.pop) begin
      rd_id <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (q_ctl.push) begin
        tail <= (tail == LAST_IDX) ? '0 : tail + 1'b1;
      end
      if (q_ctl.pop) begin
        head <= (head == LAST_IDX) ? '0 : head + 1'b1;
      end
      if (q_ctl.push && !q_ctl.pop) begin
        fill <= fill + 1'b1;
      end else if (q_ctl.pop && !q_ctl.push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  assign q_stat.full  = (fill == FULL_CNT);
  assign q_stat.empty = (fill == '0);

endmodule

### src/csem_ctrl.sv
module csem_ctrl
  import csem_pkg::*;
#(
  parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_load,
  input  logic signed [CNT_BITS-1:0] cfg_count,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_cmd,
  input  logic [THREAD_ID_BITS-1:0]  in_id,
  output q_ctl_t                     q_ctl,
  output logic [THREAD_ID_BITS-1:0]  push_id,
  input  q_stat_t                    q_stat,
  input  logic [THREAD_ID_BITS-1:0]  rd_id,
  output logic                       out_valid,
  input  logic                       out_ready,
  output kind_t                      out_kind,
  output logic [THREAD_ID_BITS-1:0]  out_id,
  output logic                       out_failed,
  output logic                       out_last
);

  state_t state, state_next;
  logic signed [CNT_BITS-1:0] count, count_next;
  logic closing, closing_next;
  logic draining, draining_next;
  kind_t res_kind, res_kind_next;
  logic [THREAD_ID_BITS-1:0] res_id, res_id_next;

  logic out_free;
  logic out_load;
  kind_t out_kind_next;
  logic [THREAD_ID_BITS-1:0] out_id_next;
  logic out_failed_next;
  logic out_last_next;
  logic signed [CNT_BITS-1:0] cnt_dec;
  logic signed [CNT_BITS-1:0] cnt_inc;

  assign out_free = !out_valid || out_ready;
  assign cnt_dec  = (count == CNT_MIN) ? CNT_MIN : count - 16'sd1;
  assign cnt_inc  = (count == CNT_MAX) ? CNT_MAX : count + 16'sd1;
  assign push_id  = in_id;

  always_comb begin
    state_next      = state;
    count_next      = count;
    closing_next    = closing;
    draining_next   = draining;
    res_kind_next   = res_kind;
    res_id_next     = res_id;
    q_ctl           = '0;
    in_ready        = 1'b0;
    out_load        = 1'b0;
    out_kind_next   = res_kind;
    out_id_next     = res_id;
    out_failed_next = 1'b0;
    out_last_next   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_cmd)
            CMD_WAIT: begin
              res_id_next = in_id;
              state_next  = ST_EMIT;
              if (count <= CNT_ZERO) begin
                if (q_stat.full) begin
                  res_kind_next = KIND_OVERFLOW;
                end else begin
                  q_ctl.push    = 1'b1;
                  count_next    = cnt_dec;
                  res_kind_next = KIND_BLOCKED;
                end
              end else begin
                count_next    = cnt_dec;
                res_kind_next = KIND_GRANTED;
              end
            end
            CMD_SIGNAL: begin
              count_next = cnt_inc;
              if (cnt_inc <= CNT_ZERO && !q_stat.empty) begin
                q_ctl.pop     = 1'b1;
                draining_next = 1'b0;
                state_next    = ST_WAKE;
              end
            end
            CMD_CLOSE: begin
              closing_next = 1'b1;
              if (!q_stat.empty) begin
                q_ctl.pop     = 1'b1;
                draining_next = 1'b1;
                state_next    = ST_WAKE;
              end else begin
                res_kind_next = KIND_DONE;
                res_id_next   = '0;
                state_next    = ST_EMIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_WAKE: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_kind_next   = KIND_WOKEN;
          out_id_next     = rd_id;
          out_failed_next = closing;
          out_last_next   = !draining;
          if (!draining) begin
            state_next = ST_IDLE;
          end else if (!q_stat.empty) begin
            // overlap the next read with this result
            q_ctl.pop = 1'b1;
          end else begin
            res_kind_next = KIND_DONE;
            res_id_next   = '0;
            state_next    = ST_EMIT;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= CNT_ZERO;
      closing   <= 1'b0;
      draining  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      closing  <= closing_next;
      draining <= draining_next;
      count    <= cfg_load ? cfg_count : count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_kind <= res_kind_next;
    res_id   <= res_id_next;
    if (out_load) begin
      out_kind   <= out_kind_next;
      out_id     <= out_id_next;
      out_failed <= out_failed_next;
      out_last   <= out_last_next;
    end
  end

endmodule

### src/counting_semaphore_wait_queue_top.sv
// a wait result goes through the EMIT state to the output register, a wake through WAKE
// wait and waking signals block the next word until the result loads; silent ones do not
// close wakes all, one wake a cycle from the queue memory read port when not stalled
// reset (synchronous, active high) empties the queue, clears closing and sets count to 0
// queue memory contents are not cleared; only entries between head and tail are read
`include "assert_macros.svh"

module counting_semaphore_wait_queue_top
  import csem_pkg::*;
#(
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
  parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF,
  localparam int TDATA_BITS    = ((THREAD_ID_BITS + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [TDATA_BITS-1:0]    s_axis_tdata,   // thread_id
  input  logic [1:0]               s_axis_tuser,   // command
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [TDATA_BITS-1:0]    m_axis_tdata,   // thread_id_out
  output logic [3:0]               m_axis_tuser,   // failed, kind
  output logic                     m_axis_tlast,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  logic signed [CNT_BITS-1:0] initial_count;
  logic cfg_load;
  q_ctl_t q_ctl;
  q_stat_t q_stat;
  logic [THREAD_ID_BITS-1:0] push_id;
  logic [THREAD_ID_BITS-1:0] rd_id;
  logic [THREAD_ID_BITS-1:0] out_id;
  kind_t out_kind;
  logic out_failed;

  assign pready   = 1'b1;
  assign cfg_load = psel && penable && pwrite && !paddr[2];
  assign prdata   = {{(APB_DATA_BITS - CNT_BITS){initial_count[CNT_BITS-1]}}, initial_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_count <= CNT_ZERO;
    end else if (cfg_load) begin
      initial_count <= pwdata[CNT_BITS-1:0];
    end
  end

  csem_queue #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_ctl   (q_ctl),
    .push_id (push_id),
    .q_stat  (q_stat),
    .rd_id   (rd_id)
  );

  csem_ctrl #(
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_load   (cfg_load),
    .cfg_count  (pwdata[CNT_BITS-1:0]),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_cmd     (s_axis_tuser),
    .in_id      (s_axis_tdata[THREAD_ID_BITS-1:0]),
    .q_ctl      (q_ctl),
    .push_id    (push_id),
    .q_stat     (q_stat),
    .rd_id      (rd_id),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_kind   (out_kind),
    .out_id     (out_id),
    .out_failed (out_failed),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = TDATA_BITS'(out_id);
  assign m_axis_tuser = {out_failed, out_kind};

  `CSEM_ASSERT(a_full_empty_excl, !(q_stat.full && q_stat.empty), "queue full and empty")
  `CSEM_ASSERT(a_push_pop_excl, !(q_ctl.push && q_ctl.pop), "push and pop together")
  `CSEM_ASSERT_IMP(a_no_push_full, q_ctl.push, !q_stat.full, "push into full queue")
  `CSEM_ASSERT_IMP(a_no_pop_empty, q_ctl.pop, !q_stat.empty, "pop from empty queue")
  `CSEM_ASSERT_IMP(a_done_last, m_axis_tvalid && (out_kind == KIND_DONE), m_axis_tlast, "done not last")

endmodule
